/* rtl/core/tam_pkg.sv */
// ----------------------------------------------------------------------------
// Thermometer average/min-max package
// Shared widths, constants, codes and stream payload types for the
// thermometer core.
// ----------------------------------------------------------------------------
package tam_pkg;

	// Running average length. Must be a power of two: the average is taken
	// with a biased arithmetic shift.
	localparam int AVG_COUNT = 16;
	localparam int AVG_SHIFT = $clog2(AVG_COUNT);

	// Temperature values are signed tenths of a degree.
	localparam int TEMP_W = 13;
	localparam int SUM_W  = TEMP_W + AVG_SHIFT;
	localparam int CODE_W = 12;
	localparam int PROD_W = 25;

	localparam logic [12:0]              TEMP_GAIN   = 13'd4230;
	localparam logic signed [TEMP_W:0]   TEMP_OFFSET = 14'sd2780;
	localparam logic signed [TEMP_W-1:0] MAX_RESET   = -13'sd999;
	localparam logic signed [TEMP_W-1:0] MIN_RESET   = 13'sd1999;
	localparam logic signed [TEMP_W-1:0] MARK_LIMIT  = -13'sd99;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_JUMP_BAND      = 2'd0,
		CFG_HOLD_TICKS     = 2'd1,
		CFG_DISPLAY_PERIOD = 2'd2
	} cfg_idx_t;

	localparam logic [7:0] JUMP_BAND_RST      = 8'd5;
	localparam logic [7:0] HOLD_TICKS_RST     = 8'd5;
	localparam logic [3:0] DISPLAY_PERIOD_RST = 4'd3;

	// Input item kind (carried on tuser).
	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_KEY    = 1'b1
	} cmd_t;

	// Display mode.
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_MAX    = 2'd1,
		MODE_MIN    = 2'd2
	} mode_t;

	// Key edge flags.
	localparam logic [1:0] KEY_MAX  = 2'd1;
	localparam logic [1:0] KEY_MIN  = 2'd2;
	localparam logic [1:0] KEYS_BOTH_HELD = 2'd0;

	// Sign mark codes.
	localparam logic [1:0] MARK_NONNEG = 2'd0;
	localparam logic [1:0] MARK_SMALL  = 2'd1;
	localparam logic [1:0] MARK_LARGE  = 2'd2;

	// Input payload: adc_code [11:0], key_flags [13:12], key_levels [15:14].
	typedef struct packed {
		logic [1:0]        key_levels;
		logic [1:0]        key_flags;
		logic [CODE_W-1:0] adc_code;
	} in_data_t;

	// Result payload: shown_value [12:0], sign_mark [14:13], zero [15].
	typedef struct packed {
		logic                     pad;
		logic [1:0]               sign_mark;
		logic signed [TEMP_W-1:0] shown_value;
	} out_data_t;

endpackage

/* rtl/core/thermometer_average_minmax.sv */
// ----------------------------------------------------------------------------
// Thermometer core with running average and min/max hold
// Converts ADC codes to tenths of a degree, keeps a leaky running average,
// tracks maximum and minimum and produces one display transaction per
// display tick or key event.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  ----------------------------------
//  s_*       in         tvalid / tready    tuser: cmd; tdata: adc_code,
//                                          key_flags, key_levels
//  m_*       out        tvalid / tready    tuser: shown_mode; tdata:
//                                          shown_value, sign_mark
//  cfg_*     in         cfg_we only        cfg_addr, cfg_wdata
//
// Each input transaction is captured in an input register and processed,
// once the result register can take a result, by one pass of logic (a
// constant multiply, the average shift, the sum update, the band compares
// and the max/min compares) that updates the state and loads the result
// register. One transaction per cycle is sustained while m_tready is high;
// a held result stalls the input register only when it is still full.
// Reset puts core state and configuration at their reset values; there is no
// clearing pass. Sample ticks that are not display ticks produce no result.
//
module thermometer_average_minmax (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tam_pkg::in_data_t   s_tdata,   // adc_code, key_flags, key_levels
	input  logic                s_tuser,   // cmd
	// Result stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output tam_pkg::out_data_t  m_tdata,   // shown_value, sign_mark, zero pad
	output logic [1:0]          m_tuser,   // shown_mode
	// Configuration write port.
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [7:0]          cfg_wdata
);
	import tam_pkg::*;

	// Configuration registers.
	logic [7:0] jump_band_q;
	logic [7:0] hold_ticks_q;
	logic [3:0] display_period_q;

	// Input register.
	logic       valid_s1;
	cmd_t       cmd_s1;
	in_data_t   data_s1;

	// Core state.
	logic signed [SUM_W-1:0]  avg_sum_q;
	logic signed [TEMP_W-1:0] avg_value_q;
	logic signed [TEMP_W-1:0] last_temp_q;
	logic signed [TEMP_W-1:0] max_seen_q;
	logic signed [TEMP_W-1:0] min_seen_q;
	logic [3:0]               tick_count_q;
	logic [7:0]               hold_timer_q;
	mode_t                    show_mode_q;

	// Result register.
	logic                     m_valid_q;
	out_data_t                m_data_q;
	mode_t                    m_mode_q;

	// Process the captured transaction when the result register can take a
	// result. Items without a result wait on the same condition, so a plain
	// sample tick also waits behind a held result.
	logic advance;
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// ------------------------------------------------------------------
	// Datapath for one transaction.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]        prod;
	logic signed [TEMP_W:0]   temp_w;
	logic signed [TEMP_W-1:0] temp;
	logic signed [SUM_W-1:0]  sum_bias;
	logic signed [TEMP_W-1:0] avg_cur;
	logic signed [SUM_W-1:0]  sum_leak;
	logic [3:0]               tick_inc;
	logic                     disp_tick;
	logic signed [TEMP_W:0]   band_hi;
	logic signed [TEMP_W:0]   band_lo;
	logic                     jump;
	logic signed [TEMP_W-1:0] avg_disp;
	logic signed [TEMP_W-1:0] abs_avg;
	logic signed [TEMP_W-1:0] max_disp;
	logic signed [TEMP_W-1:0] min_disp;
	mode_t                    key_mode;
	logic [1:0]               disp_mark;
	logic [1:0]               key_mark;

	// Temperature: ((code * 4230) >> 12) - 2780.
	assign prod   = PROD_W'(data_s1.adc_code) * PROD_W'(TEMP_GAIN);
	assign temp_w = $signed({1'b0, prod[PROD_W-1:CODE_W]}) - TEMP_OFFSET;
	assign temp   = TEMP_W'(temp_w);

	// Average of the previous sum, truncated toward zero.
	assign sum_bias = avg_sum_q[SUM_W-1] ? (avg_sum_q + SUM_W'(AVG_COUNT - 1)) : avg_sum_q;
	assign avg_cur  = TEMP_W'(sum_bias >>> AVG_SHIFT);
	assign sum_leak = SUM_W'((SUM_W+1)'(avg_sum_q) + (SUM_W+1)'(temp) - (SUM_W+1)'(avg_cur));

	// A display tick comes when the incremented count reaches the period.
	assign tick_inc  = tick_count_q + 4'd1;
	assign disp_tick = (tick_inc >= display_period_q);

	// Reload the average when the sample leaves the band around it.
	assign band_hi  = (TEMP_W+1)'(avg_cur) + $signed({6'd0, jump_band_q});
	assign band_lo  = (TEMP_W+1)'(avg_cur) - $signed({6'd0, jump_band_q});
	assign jump     = ((TEMP_W+1)'(temp) > band_hi) || ((TEMP_W+1)'(temp) < band_lo);
	assign avg_disp = jump ? temp : avg_cur;
	assign abs_avg  = avg_disp[TEMP_W-1] ? -avg_disp : avg_disp;
	assign max_disp = (avg_disp > max_seen_q) ? avg_disp : max_seen_q;
	assign min_disp = (avg_disp < min_seen_q) ? avg_disp : min_seen_q;

	assign disp_mark = !avg_disp[TEMP_W-1] ? MARK_NONNEG :
		((avg_disp > MARK_LIMIT) ? MARK_SMALL : MARK_LARGE);
	assign key_mark  = !avg_value_q[TEMP_W-1] ? MARK_NONNEG :
		((avg_value_q > MARK_LIMIT) ? MARK_SMALL : MARK_LARGE);

	// Key mode: both flags set selects nothing valid and falls back to normal.
	always_comb begin
		unique case (data_s1.key_flags)
			KEY_MAX: key_mode = MODE_MAX;
			KEY_MIN: key_mode = MODE_MIN;
			default: key_mode = MODE_NORMAL;
		endcase
	end

	// ------------------------------------------------------------------
	// Next state and result.
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0]  avg_sum_d;
	logic signed [TEMP_W-1:0] avg_value_d;
	logic signed [TEMP_W-1:0] last_temp_d;
	logic signed [TEMP_W-1:0] max_seen_d;
	logic signed [TEMP_W-1:0] min_seen_d;
	logic [3:0]               tick_count_d;
	logic [7:0]               hold_timer_d;
	mode_t                    show_mode_d;
	logic                     emit;
	out_data_t                res_data;
	mode_t                    res_mode;

	always_comb begin
		avg_sum_d    = avg_sum_q;
		avg_value_d  = avg_value_q;
		last_temp_d  = last_temp_q;
		max_seen_d   = max_seen_q;
		min_seen_d   = min_seen_q;
		tick_count_d = tick_count_q;
		hold_timer_d = hold_timer_q;
		show_mode_d  = show_mode_q;
		emit         = 1'b0;
		res_data     = '0;
		res_mode     = MODE_NORMAL;

		if (cmd_s1 == CMD_KEY) begin
			// Key event: pick the mode, or with both keys held reset max/min.
			emit         = 1'b1;
			hold_timer_d = hold_ticks_q;
			if (data_s1.key_levels == KEYS_BOTH_HELD) begin
				max_seen_d  = MAX_RESET;
				min_seen_d  = MIN_RESET;
				show_mode_d = MODE_NORMAL;
			end else begin
				show_mode_d = key_mode;
			end
			res_mode           = show_mode_d;
			res_data.sign_mark = key_mark;
			unique case (show_mode_d)
				MODE_MAX: res_data.shown_value = max_seen_d;
				MODE_MIN: res_data.shown_value = min_seen_d;
				default:  res_data.shown_value = last_temp_q;
			endcase
		end else if (!disp_tick) begin
			// Plain sample tick: feed the average, no result.
			avg_sum_d    = sum_leak;
			avg_value_d  = avg_cur;
			last_temp_d  = temp;
			tick_count_d = tick_inc;
		end else begin
			// Display tick.
			emit         = 1'b1;
			avg_sum_d    = jump ? (SUM_W'(temp) <<< AVG_SHIFT) : sum_leak;
			avg_value_d  = avg_disp;
			max_seen_d   = max_disp;
			min_seen_d   = min_disp;
			last_temp_d  = abs_avg;
			tick_count_d = '0;
			res_mode           = show_mode_q;
			res_data.sign_mark = disp_mark;
			unique case (show_mode_q)
				MODE_MAX: res_data.shown_value = max_disp;
				MODE_MIN: res_data.shown_value = min_disp;
				default:  res_data.shown_value = abs_avg;
			endcase
			if (hold_timer_q != 8'd0) begin
				hold_timer_d = hold_timer_q - 8'd1;
			end else begin
				show_mode_d = MODE_NORMAL;
			end
		end
	end

	// ------------------------------------------------------------------
	// Registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_band_q      <= JUMP_BAND_RST;
			hold_ticks_q     <= HOLD_TICKS_RST;
			display_period_q <= DISPLAY_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_JUMP_BAND:      jump_band_q      <= cfg_wdata;
				CFG_HOLD_TICKS:     hold_ticks_q     <= cfg_wdata;
				CFG_DISPLAY_PERIOD: display_period_q <= cfg_wdata[3:0];
				default:            ;
			endcase
		end
	end

	// Input register: the valid bit is control, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_sum_q    <= '0;
			avg_value_q  <= '0;
			last_temp_q  <= '0;
			max_seen_q   <= MAX_RESET;
			min_seen_q   <= MIN_RESET;
			tick_count_q <= '0;
			hold_timer_q <= '0;
			show_mode_q  <= MODE_NORMAL;
		end else if (advance) begin
			avg_sum_q    <= avg_sum_d;
			avg_value_q  <= avg_value_d;
			last_temp_q  <= last_temp_d;
			max_seen_q   <= max_seen_d;
			min_seen_q   <= min_seen_d;
			tick_count_q <= tick_count_d;
			hold_timer_q <= hold_timer_d;
			show_mode_q  <= show_mode_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_data_q <= res_data;
			m_mode_q <= res_mode;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_mode_q;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Thermometer average/min-max core regression bench
// Feeds sample ticks and key events into the core. The input stream runs in
// bursts with gaps, and the result stream stalls on a pattern of its own.
// A behavioral predictor in this module computes every expected display
// transaction, and each result is checked field by field against it. The
// configuration is changed between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb;
	import tam_pkg::*;

	// Idle cycles allowed after the last expected result before the core is
	// considered quiet. That covers the input register, the processing pass
	// and a plain sample tick that produces no result.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	// Key codes that the package does not name.
	localparam logic [1:0] KEY_NONE        = 2'b00;
	localparam logic [1:0] LEVELS_RELEASED = ~KEYS_BOTH_HELD;
	// The last index of the write port selects no register.
	localparam logic [1:0] CFG_SPARE       = 2'd3;

	// ADC codes for the directed part: both ends of the range, roughly zero
	// degrees, a few degrees below zero and about twenty degrees below zero.
	localparam logic [CODE_W-1:0] ADC_LOW     = '0;
	localparam logic [CODE_W-1:0] ADC_HIGH    = '1;
	localparam logic [CODE_W-1:0] ADC_ZERO    = 12'd2692;
	localparam logic [CODE_W-1:0] ADC_SUBZERO = 12'd2650;
	localparam logic [CODE_W-1:0] ADC_COLD    = 12'd2500;

	// One item for the input stream: the cmd travels on tuser.
	typedef struct packed {
		cmd_t     cmd;
		in_data_t data;
	} stim_t;

	// One expected display transaction.
	typedef struct packed {
		logic signed [TEMP_W-1:0] value;
		logic [1:0]               mode;
		logic [1:0]               mark;
	} display_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      s_tvalid  = 1'b0;
	logic      s_tready;
	in_data_t  s_tdata   = '0;
	logic      s_tuser   = CMD_SAMPLE;
	logic      m_tvalid;
	logic      m_tready  = 1'b0;
	out_data_t m_tdata;
	logic [1:0] m_tuser;
	logic      cfg_we    = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [7:0] cfg_wdata = '0;

	// Stimulus and checking bookkeeping.
	stim_t    pending_items[$];
	display_t expected_display[$];
	int       mismatches    = 0;
	int       cycle_count   = 0;
	int       walk_code     = 2692;
	bit       sender_calm   = 1'b0;
	bit       receiver_calm = 1'b0;

	// Predictor copy of the configuration registers.
	logic [7:0] band_reg   = JUMP_BAND_RST;
	logic [7:0] hold_reg   = HOLD_TICKS_RST;
	logic [3:0] period_reg = DISPLAY_PERIOD_RST;

	// Predictor state, starting from the reset values of the core.
	int         run_sum      = 0;
	int         run_avg      = 0;
	int         current_view = 0;
	int         peak_avg     = int'(MAX_RESET);
	int         trough_avg   = int'(MIN_RESET);
	logic [3:0] tick_cnt     = '0;
	logic [7:0] hold_cnt     = '0;
	logic [1:0] view_mode    = MODE_NORMAL;

	thermometer_average_minmax uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Builds the display transaction from the current state. A selected mode
	// of 3 (both key edges at once) is out of range and falls back to normal
	// mode here, and that fallback sticks in the state.
	function automatic display_t form_display();
		display_t shown;
		int       v;
		if (view_mode > MODE_MIN) view_mode = MODE_NORMAL;
		case (view_mode)
			MODE_MAX: v = peak_avg;
			MODE_MIN: v = trough_avg;
			default: v = current_view;
		endcase
		shown.value = v[TEMP_W-1:0];
		shown.mode  = view_mode;
		if (run_avg >= 0) shown.mark = MARK_NONNEG;
		else if (run_avg > int'(MARK_LIMIT)) shown.mark = MARK_SMALL;
		else shown.mark = MARK_LARGE;
		return shown;
	endfunction

	// Advances the thermometer state by one accepted input transaction and
	// returns 1 when that transaction causes a display transaction.
	function automatic bit advance_thermometer(input cmd_t cmd, input in_data_t d,
			output display_t shown);
		int unsigned prod;
		int          temp;
		shown = '0;
		if (cmd == CMD_KEY) begin
			// Key event: pick the mode, or with both keys held restart the
			// max/min tracking. The hold timer is always reloaded.
			view_mode = d.key_flags;
			if (d.key_levels == KEYS_BOTH_HELD) begin
				peak_avg   = int'(MAX_RESET);
				trough_avg = int'(MIN_RESET);
				view_mode  = MODE_NORMAL;
			end
			hold_cnt = hold_reg;
			shown = form_display();
			return 1'b1;
		end
		// Sample tick: convert, then fold into the leaky sum. The average is
		// taken from the sum before the new sample goes in, and the division
		// truncates toward zero.
		prod = 32'(d.adc_code) * 32'(TEMP_GAIN);
		temp = int'(prod >> 12) - int'(TEMP_OFFSET);
		current_view = temp;
		run_avg = run_sum / AVG_COUNT;
		run_sum = run_sum + temp - run_avg;
		tick_cnt = tick_cnt + 4'd1;
		if (tick_cnt < period_reg) return 1'b0;

		// Display tick. A sample that has left the band around the average
		// restarts the sum from that sample alone.
		if (temp > run_avg + int'(band_reg) || temp < run_avg - int'(band_reg)) begin
			run_sum = temp * AVG_COUNT;
			run_avg = run_sum / AVG_COUNT;
		end
		if (run_avg > peak_avg) peak_avg = run_avg;
		if (run_avg < trough_avg) trough_avg = run_avg;
		// Normal mode shows the magnitude; the sign goes out as the mark.
		current_view = (run_avg < 0) ? -run_avg : run_avg;
		shown = form_display();
		tick_cnt = '0;
		if (hold_cnt != 0) hold_cnt = hold_cnt - 8'd1;
		else view_mode = MODE_NORMAL;
		return 1'b1;
	endfunction

	function automatic stim_t sample_item(input logic [CODE_W-1:0] code);
		stim_t item;
		item.cmd             = CMD_SAMPLE;
		item.data.adc_code   = code;
		// Key fields are ignored on a sample tick; keep them random.
		item.data.key_flags  = 2'($urandom);
		item.data.key_levels = 2'($urandom);
		return item;
	endfunction

	function automatic stim_t key_item(input logic [1:0] flags, input logic [1:0] levels);
		stim_t item;
		item.cmd             = CMD_KEY;
		item.data.adc_code   = CODE_W'($urandom);
		item.data.key_flags  = flags;
		item.data.key_levels = levels;
		return item;
	endfunction

	// Queues a mix of key events and samples. Most samples follow a slow
	// random walk so that the running average settles and the band check
	// goes both ways; the rest jump anywhere, to the ends of the range, or
	// near zero degrees where the small negative mark lives.
	task automatic queue_walk(input int count);
		int roll;
		int stride;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				pending_items.push_back(key_item(2'($urandom),
					($urandom_range(0, 3) == 0) ? KEYS_BOTH_HELD : 2'($urandom)));
			end else begin
				if (roll < 20) walk_code = $urandom_range(0, 4095);
				else if (roll < 23) walk_code = ($urandom_range(0, 1) != 0) ? 4095 : 0;
				else if (roll < 28) walk_code = $urandom_range(2560, 2720);
				else begin
					stride = int'($urandom_range(0, 12)) - 6;
					walk_code = walk_code + stride;
					if (walk_code < 0) walk_code = 0;
					if (walk_code > 4095) walk_code = 4095;
				end
				pending_items.push_back(sample_item(walk_code[CODE_W-1:0]));
			end
		end
	endtask

	// Waits until every item is sent and every result has arrived, then lets
	// the core finish any plain sample tick still in flight.
	task automatic settle();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_display.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Configuration write; the core must be idle.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_JUMP_BAND:      band_reg   = val;
			CFG_HOLD_TICKS:     hold_reg   = val;
			CFG_DISPLAY_PERIOD: period_reg = val[3:0];
			default: ;
		endcase
	endtask

	// One phase: settle, write every register, then queue random items. The
	// display period write carries random upper bits, which the register
	// drops. The tick count is left as the last phase ended, so lowering the
	// period below it is exercised.
	task automatic run_phase(input logic [7:0] band, input logic [7:0] hold,
			input logic [3:0] period, input int count, input bit calm);
		settle();
		write_reg(CFG_JUMP_BAND, band);
		write_reg(CFG_HOLD_TICKS, hold);
		write_reg(CFG_DISPLAY_PERIOD, {4'($urandom), period});
		sender_calm   = calm;
		receiver_calm = calm;
		queue_walk(count);
	endtask

	// Input driver: presents the next pending item whenever the current one
	// has been taken, with random gaps between bursts. Each accepted
	// transaction goes through the predictor at the same edge.
	always @(posedge clk or negedge arst_n) begin : input_driver
		stim_t    next_item;
		display_t predicted;
		int       burst_left;
		int       gap_left;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (advance_thermometer(cmd_t'(s_tuser), s_tdata, predicted))
					expected_display.push_back(predicted);
			end
			if (!s_tvalid || s_tready) begin
				if (!sender_calm && gap_left > 0) begin
					gap_left = gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.data;
					s_tuser  <= next_item.cmd;
					if (burst_left > 0) begin
						burst_left = burst_left - 1;
					end else begin
						// Mostly short gaps, now and then a long one.
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
							: $urandom_range(1, 4);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted display transaction against the
	// oldest expectation and toggles m_tready on runs of random length.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		display_t want;
		int       pattern_left;
		if (!arst_n) begin
			m_tready <= 1'b0;
			pattern_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_display.size() == 0) begin
					$error("unexpected display transaction: shown_value %0d shown_mode %0d",
						m_tdata.shown_value, m_tuser);
					mismatches++;
				end else begin
					want = expected_display.pop_front();
					if (m_tdata.shown_value !== want.value) begin
						$error("shown_value: expected %0d, got %0d", want.value,
							m_tdata.shown_value);
						mismatches++;
					end
					if (m_tuser !== want.mode) begin
						$error("shown_mode: expected %0d, got %0d", want.mode, m_tuser);
						mismatches++;
					end
					if (m_tdata.sign_mark !== want.mark) begin
						$error("sign_mark: expected %0d, got %0d", want.mark,
							m_tdata.sign_mark);
						mismatches++;
					end
					if (m_tdata.pad !== 1'b0) begin
						$error("pad: expected 0, got %b", m_tdata.pad);
						mismatches++;
					end
				end
			end
			if (receiver_calm) begin
				m_tready <= 1'b1;
			end else if (pattern_left > 0) begin
				pattern_left = pattern_left - 1;
			end else begin
				m_tready <= !m_tready;
				pattern_left = m_tready ? $urandom_range(0, 6) : $urandom_range(0, 10);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("thermometer_average_minmax regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset configuration: initial max and min
		// shown by key, the ends of the ADC range, out-of-range mode from
		// both key edges, both keys held, a single key held, and averages
		// at zero, slightly below zero and well below zero.
		pending_items.push_back(key_item(KEY_MAX, LEVELS_RELEASED));
		pending_items.push_back(key_item(KEY_MIN, LEVELS_RELEASED));
		repeat (3) pending_items.push_back(sample_item(ADC_HIGH));
		repeat (3) pending_items.push_back(sample_item(ADC_LOW));
		pending_items.push_back(key_item(KEY_MAX | KEY_MIN, LEVELS_RELEASED));
		pending_items.push_back(key_item(KEY_MAX, KEYS_BOTH_HELD));
		repeat (3) pending_items.push_back(sample_item(ADC_SUBZERO));
		repeat (3) pending_items.push_back(sample_item(ADC_ZERO));
		pending_items.push_back(key_item(KEY_NONE, LEVELS_RELEASED));
		pending_items.push_back(key_item(KEY_MIN, ~KEY_MIN));
		pending_items.push_back(key_item(KEY_MAX, ~KEY_MAX));
		repeat (3) pending_items.push_back(sample_item(ADC_COLD));
		pending_items.push_back(key_item(KEY_MIN, LEVELS_RELEASED));
		queue_walk(130);

		// Extremes: zero band and hold with a display on every tick, then
		// the widest band and longest hold with the longest period, then a
		// short period after it, then a period of zero.
		run_phase(8'd0, 8'd0, 4'd1, 130, 1'b0);
		run_phase(8'd255, 8'd255, 4'd15, 180, 1'b1);
		run_phase(8'd5, 8'd3, 4'd2, 130, 1'b0);
		run_phase(8'd0, 8'd255, 4'd0, 130, 1'b0);

		// A write to the unused index must leave every register alone.
		settle();
		write_reg(CFG_SPARE, 8'($urandom));

		repeat (4)
			run_phase(8'($urandom), 8'($urandom), 4'($urandom), 130,
				$urandom_range(0, 3) == 0);

		settle();
		if (mismatches == 0) begin
			$display("thermometer_average_minmax regression: pass");
		end else begin
			$display("thermometer_average_minmax regression: fail");
		end
		$finish;
	end

endmodule

/* thermometer_average_minmax.f */
rtl/core/tam_pkg.sv
rtl/core/thermometer_average_minmax.sv
tb/sv/tb.sv
